// File: rtl/cst_pkg.sv
// Shared types, constants and calendar helper functions for the
// calendar_second_tick block. No dependencies.
package cst_pkg;

    localparam int SDATA_W = 56;
    localparam int MDATA_W = 112;

    // Reset state: 2015-01-01 00:00:00 local time, UTC+1.
    localparam logic [5:0]  RST_SEC       = 6'd0;
    localparam logic [5:0]  RST_MIN       = 6'd0;
    localparam logic [4:0]  RST_HOUR      = 5'd0;
    localparam logic [4:0]  RST_DAY       = 5'd1;
    localparam logic [3:0]  RST_MONTH     = 4'd1;
    localparam logic [6:0]  RST_YEAR      = 7'd15;
    localparam logic [6:0]  RST_CENTURY   = 7'd20;
    localparam logic [2:0]  RST_WEEKDAY   = 3'd4;
    localparam logic [4:0]  RST_ZONE      = 5'd1;
    localparam logic [21:0] RST_DAY_COUNT = 22'd16436;
    localparam logic [37:0] RST_SEC_COUNT = 38'd1420066800;

    // Day-number building blocks
    localparam int DAYS_1970_TO_2000 = 365 * 30 + 7;
    localparam int DAYS_PER_400Y     = 365 * 400 + 97;
    localparam int DAYS_CENT_NOLEAP  = 365 * 100 + 24;
    localparam int DAYS_CENT_LEAP    = 365 * 100 + 25;
    localparam logic [6:0] CENTURY_WRAP_TO = 7'd40;
    localparam logic [6:0] CENTURY_WRAP_AT = 7'd100;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_FLAGS = 2'd1,
        KIND_LOAD  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_MONTH,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_FLAGS,
        OP_LOAD,
        OP_BASE,
        OP_MONTH,
        OP_DAY,
        OP_S1,
        OP_S2,
        OP_S3
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   publish;
    } dp_cmd_t;

    typedef struct packed {
        logic tick_wrap;   // tick at hand rolls century 99 over, wrapping to 40
        logic month_more;  // month sum not finished
    } dp_sts_t;

    // Input word, lowest field in the lowest bits
    typedef struct packed {
        logic [5:0] pad;
        logic [4:0] load_zone;
        logic [2:0] load_weekday;
        logic [6:0] load_century;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
        logic       zone_announce;
        logic       leap_announce;
    } in_word_t;

    // Result word, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [1:0]  pending_flags;
        logic [37:0] seconds_count;
        logic [21:0] day_number;
        logic [4:0]  zone;
        logic [2:0]  weekday;
        logic [6:0]  century;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } out_word_t;

    function automatic logic [4:0] month_length(
        input logic [3:0] m,
        input logic [6:0] y,
        input logic [6:0] c
    );
        logic leap;
        leap = (y[1:0] == 2'b00) && ((y != 7'd0) || (c[1:0] == 2'b00));
        case (m)
            4'd2:                           month_length = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:        month_length = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                   month_length = 5'd31;
            default:                        month_length = 5'd0;
        endcase
    endfunction

    // Days from 1970-01-01 to the first day of century c (modulo 2^22).
    function automatic logic [21:0] century_days(input logic [6:0] c);
        int d;
        d = DAYS_1970_TO_2000 + (int'(c[6:2]) - 5) * DAYS_PER_400Y;
        if (c[1:0] >= 2'd1) d = d + DAYS_CENT_LEAP;
        if (c[1:0] >= 2'd2) d = d + DAYS_CENT_NOLEAP;
        if (c[1:0] >= 2'd3) d = d + DAYS_CENT_NOLEAP;
        century_days = d[21:0];
    endfunction

endpackage

// File: rtl/cst_ctrl.sv
// Controller for calendar_second_tick: sequences a tick, flag write, load
// and the count recompute, and owns the result valid. Depends on cst_pkg.
module cst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [1:0]        s_tuser,
    output logic              s_tready,
    input  logic              m_tready,
    output logic              m_tvalid,
    input  cst_pkg::dp_sts_t  sts,
    output cst_pkg::dp_cmd_t  cmd
);

    cst_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cst_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == cst_pkg::KIND_LOAD ||
                        (s_tuser == cst_pkg::KIND_TICK && sts.tick_wrap)) begin
                        state_next = cst_pkg::ST_BASE;
                    end else begin
                        state_next = cst_pkg::ST_DONE;
                    end
                end
            end
            cst_pkg::ST_BASE:  state_next = cst_pkg::ST_MONTH;
            cst_pkg::ST_MONTH: begin
                if (!sts.month_more) state_next = cst_pkg::ST_S1;
            end
            cst_pkg::ST_S1:    state_next = cst_pkg::ST_S2;
            cst_pkg::ST_S2:    state_next = cst_pkg::ST_S3;
            cst_pkg::ST_S3:    state_next = cst_pkg::ST_DONE;
            cst_pkg::ST_DONE: begin
                if (out_free) state_next = cst_pkg::ST_IDLE;
            end
            default:           state_next = cst_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready    = 1'b0;
        cmd.op      = cst_pkg::OP_NONE;
        cmd.publish = 1'b0;
        case (state_reg)
            cst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        cst_pkg::KIND_TICK:  cmd.op = cst_pkg::OP_TICK;
                        cst_pkg::KIND_FLAGS: cmd.op = cst_pkg::OP_FLAGS;
                        cst_pkg::KIND_LOAD:  cmd.op = cst_pkg::OP_LOAD;
                        default:             cmd.op = cst_pkg::OP_NONE;
                    endcase
                end
            end
            cst_pkg::ST_BASE:  cmd.op = cst_pkg::OP_BASE;
            cst_pkg::ST_MONTH: cmd.op = sts.month_more ? cst_pkg::OP_MONTH : cst_pkg::OP_DAY;
            cst_pkg::ST_S1:    cmd.op = cst_pkg::OP_S1;
            cst_pkg::ST_S2:    cmd.op = cst_pkg::OP_S2;
            cst_pkg::ST_S3:    cmd.op = cst_pkg::OP_S3;
            cst_pkg::ST_DONE:  cmd.publish = out_free;
            default:           cmd.op = cst_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// File: rtl/cst_datapath.sv
// Datapath for calendar_second_tick: calendar registers, tick carry chain,
// month-sum accumulator and result register. Depends on cst_pkg.
module cst_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cst_pkg::dp_cmd_t             cmd,
    input  logic [cst_pkg::SDATA_W-1:0]  s_tdata,
    output cst_pkg::dp_sts_t             sts,
    output logic [cst_pkg::MDATA_W-1:0]  m_tdata
);

    cst_pkg::in_word_t  in_w;
    cst_pkg::out_word_t out_w;

    logic [5:0]  sec_reg, sec_next, min_reg, min_next;
    logic [4:0]  hour_reg, hour_next, day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [6:0]  year_reg, year_next, century_reg, century_next;
    logic [2:0]  weekday_reg, weekday_next;
    logic [4:0]  zone_reg, zone_next;
    logic [21:0] day_count_reg, day_count_next;
    logic [37:0] sec_count_reg, sec_count_next;
    logic        leap_pend_reg, leap_pend_next, zone_pend_reg, zone_pend_next;
    logic [37:0] acc_reg, acc_next;
    logic [3:0]  mcnt_reg, mcnt_next;
    logic [cst_pkg::MDATA_W-1:0] out_reg;

    // tick results
    logic [5:0]  tk_sec, tk_min;
    logic [4:0]  tk_hour, tk_day, tk_zone;
    logic [3:0]  tk_month;
    logic [6:0]  tk_year, tk_century;
    logic [2:0]  tk_weekday;
    logic [21:0] tk_day_count;
    logic [37:0] tk_sec_count;
    logic        tk_leap_pend, tk_zone_pend, tk_wrap;
    logic [6:0]  s7, mi7, c7;
    logic [5:0]  h6, dd6;
    logic [4:0]  mo5;
    logic [7:0]  y8;
    logic [3:0]  w4;

    logic [21:0] year_term;
    logic [15:0] year_days;
    logic [37:0] hz_sum, acc_x60;

    assign in_w = cst_pkg::in_word_t'(s_tdata);

    always_comb begin
        s7  = {1'b0, sec_reg} + 7'd1;
        mi7 = {1'b0, min_reg} + 7'd1;
        dd6 = {1'b0, day_reg} + 6'd1;
        mo5 = {1'b0, month_reg} + 5'd1;
        y8  = {1'b0, year_reg} + 8'd1;
        c7  = century_reg + 7'd1;
        w4  = {1'b0, weekday_reg} + 4'd1;
        h6  = {1'b0, hour_reg};

        tk_sec       = sec_reg;
        tk_min       = min_reg;
        tk_hour      = hour_reg;
        tk_day       = day_reg;
        tk_month     = month_reg;
        tk_year      = year_reg;
        tk_century   = century_reg;
        tk_weekday   = weekday_reg;
        tk_zone      = zone_reg;
        tk_day_count = day_count_reg;
        tk_sec_count = sec_count_reg + 38'd1;
        tk_leap_pend = leap_pend_reg;
        tk_zone_pend = zone_pend_reg;
        tk_wrap      = 1'b0;

        if (s7 < 7'd60) begin
            tk_sec = s7[5:0];
        end else if (s7 == 7'd60 && min_reg == 6'd59 && leap_pend_reg) begin
            tk_sec = s7[5:0];
        end else begin
            tk_sec = 6'd0;
            if (mi7 < 7'd60) begin
                tk_min = mi7[5:0];
            end else begin
                tk_min = 6'd0;
                if (leap_pend_reg) begin
                    tk_sec_count = sec_count_reg;
                    tk_leap_pend = 1'b0;
                end
                if (zone_pend_reg) begin
                    tk_zone_pend = 1'b0;
                    if (zone_reg == 5'd1) begin
                        h6      = h6 + 6'd2;
                        tk_zone = 5'd2;
                    end else if (zone_reg == 5'd2) begin
                        tk_zone = 5'd1;
                    end else begin
                        h6 = h6 + 6'd1;
                    end
                end else begin
                    h6 = h6 + 6'd1;
                end
                if (h6 < 6'd24) begin
                    tk_hour = h6[4:0];
                end else begin
                    tk_hour      = 5'(h6 - 6'd24);
                    tk_weekday   = (w4 >= 4'd7) ? 3'(w4 - 4'd7) : w4[2:0];
                    tk_day_count = day_count_reg + 22'd1;
                    if (dd6 <= {1'b0, cst_pkg::month_length(month_reg, year_reg,
                                                             century_reg)}) begin
                        tk_day = dd6[4:0];
                    end else begin
                        tk_day = 5'd1;
                        if (mo5 <= 5'd12) begin
                            tk_month = mo5[3:0];
                        end else begin
                            tk_month = 4'd1;
                            if (y8 <= 8'd99) begin
                                tk_year = y8[6:0];
                            end else begin
                                tk_year    = 7'd0;
                                tk_century = c7;
                                if (c7 == cst_pkg::CENTURY_WRAP_AT) begin
                                    tk_century = cst_pkg::CENTURY_WRAP_TO;
                                    tk_wrap    = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // days from the century start to January 1 of the year
    always_comb begin
        year_days = 16'(year_reg) * 16'd365;
        if (year_reg == 7'd0) begin
            year_term = 22'd0;
        end else begin
            year_term = 22'(year_days) + 22'((8'(year_reg) + 8'd3) >> 2)
                      - ((century_reg[1:0] != 2'b00) ? 22'd1 : 22'd0);
        end
    end

    assign hz_sum  = 38'({day_count_reg, 4'b0000}) + 38'({day_count_reg, 3'b000})
                   + 38'(hour_reg) - {{33{zone_reg[4]}}, zone_reg};
    assign acc_x60 = {acc_reg[31:0], 6'b000000} - {acc_reg[35:0], 2'b00};

    always_comb begin
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        century_next   = century_reg;
        weekday_next   = weekday_reg;
        zone_next      = zone_reg;
        day_count_next = day_count_reg;
        sec_count_next = sec_count_reg;
        leap_pend_next = leap_pend_reg;
        zone_pend_next = zone_pend_reg;
        acc_next       = acc_reg;
        mcnt_next      = mcnt_reg;
        case (cmd.op)
            cst_pkg::OP_TICK: begin
                sec_next       = tk_sec;
                min_next       = tk_min;
                hour_next      = tk_hour;
                day_next       = tk_day;
                month_next     = tk_month;
                year_next      = tk_year;
                century_next   = tk_century;
                weekday_next   = tk_weekday;
                zone_next      = tk_zone;
                day_count_next = tk_day_count;
                sec_count_next = tk_sec_count;
                leap_pend_next = tk_leap_pend;
                zone_pend_next = tk_zone_pend;
            end
            cst_pkg::OP_FLAGS: begin
                leap_pend_next = in_w.leap_announce;
                zone_pend_next = in_w.zone_announce;
            end
            cst_pkg::OP_LOAD: begin
                sec_next     = in_w.load_second;
                min_next     = in_w.load_minute;
                hour_next    = in_w.load_hour;
                day_next     = in_w.load_day;
                month_next   = in_w.load_month;
                year_next    = in_w.load_year;
                century_next = in_w.load_century;
                weekday_next = in_w.load_weekday;
                zone_next    = in_w.load_zone;
            end
            cst_pkg::OP_BASE: begin
                acc_next  = 38'(cst_pkg::century_days(century_reg) + year_term);
                mcnt_next = 4'd1;
            end
            cst_pkg::OP_MONTH: begin
                acc_next  = 38'(acc_reg[21:0] + 22'(cst_pkg::month_length(mcnt_reg,
                                                    year_reg, century_reg)));
                mcnt_next = mcnt_reg + 4'd1;
            end
            cst_pkg::OP_DAY: begin
                // day 0 counts as the day before day 1
                day_count_next = acc_reg[21:0] + 22'(day_reg) - 22'd1;
            end
            cst_pkg::OP_S1: acc_next = hz_sum;
            cst_pkg::OP_S2: acc_next = acc_x60 + 38'(min_reg);
            cst_pkg::OP_S3: sec_count_next = acc_x60 + 38'(sec_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg       <= cst_pkg::RST_SEC;
            min_reg       <= cst_pkg::RST_MIN;
            hour_reg      <= cst_pkg::RST_HOUR;
            day_reg       <= cst_pkg::RST_DAY;
            month_reg     <= cst_pkg::RST_MONTH;
            year_reg      <= cst_pkg::RST_YEAR;
            century_reg   <= cst_pkg::RST_CENTURY;
            weekday_reg   <= cst_pkg::RST_WEEKDAY;
            zone_reg      <= cst_pkg::RST_ZONE;
            day_count_reg <= cst_pkg::RST_DAY_COUNT;
            sec_count_reg <= cst_pkg::RST_SEC_COUNT;
            leap_pend_reg <= 1'b0;
            zone_pend_reg <= 1'b0;
        end else begin
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            century_reg   <= century_next;
            weekday_reg   <= weekday_next;
            zone_reg      <= zone_next;
            day_count_reg <= day_count_next;
            sec_count_reg <= sec_count_next;
            leap_pend_reg <= leap_pend_next;
            zone_pend_reg <= zone_pend_next;
        end
    end

    always_comb begin
        out_w               = '0;
        out_w.second        = sec_reg;
        out_w.minute        = min_reg;
        out_w.hour          = hour_reg;
        out_w.day           = day_reg;
        out_w.month         = month_reg;
        out_w.year          = year_reg;
        out_w.century       = century_reg;
        out_w.weekday       = weekday_reg;
        out_w.zone          = zone_reg;
        out_w.day_number    = day_count_reg;
        out_w.seconds_count = sec_count_reg;
        out_w.pending_flags = {zone_pend_reg, leap_pend_reg};
    end

    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        mcnt_reg <= mcnt_next;
        if (cmd.publish) out_reg <= out_w;
    end

    assign sts.tick_wrap  = tk_wrap;
    assign sts.month_more = (mcnt_reg < month_reg);
    assign m_tdata        = out_reg;

endmodule

// File: rtl/calendar_second_tick.sv
// Top level of the Gregorian real-time clock calendar.
// Depends on cst_pkg, cst_ctrl and cst_datapath.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the kind
//   (tick, announcement flags, load) and s_tdata the flag and load fields.
//   Every accepted word returns exactly one result word on
//   m_tvalid/m_tready holding the full calendar state after that word.
//   A tick, a flag write or an unknown kind goes from acceptance straight
//   to the result handoff. A load, or a tick that rolls century 99
//   over, rebuilds the day number and seconds count: one base step, one
//   adder step per month before the current month, a day step and three
//   seconds steps, so the rebuild grows with the month. One word is
//   processed at a time.
//   The result sits in an output register; the next word is taken while an
//   earlier result still waits, and a stalled receiver only holds the
//   block once a new result is ready to replace the waiting one.
//   Reset (aresetn low, synchronous) loads 2015-01-01 00:00:00 UTC+1,
//   clears both pending flags and drops any waiting result.
module calendar_second_tick (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // kind[1:0]
    input  logic [1:0]                   s_tuser,
    // leap_announce[0], zone_announce[1], load_second[7:2],
    // load_minute[13:8], load_hour[18:14], load_day[23:19],
    // load_month[27:24], load_year[34:28], load_century[41:35],
    // load_weekday[44:42], load_zone[49:45], zero[55:50]
    input  logic [cst_pkg::SDATA_W-1:0]  s_tdata,
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22],
    // year[32:26], century[39:33], weekday[42:40], zone[47:43],
    // day_number[69:48], seconds_count[107:70], pending_flags[109:108],
    // zero[111:110]
    output logic [cst_pkg::MDATA_W-1:0]  m_tdata
);

    cst_pkg::dp_cmd_t cmd;   // controller -> datapath
    cst_pkg::dp_sts_t sts;   // datapath -> controller

    // sequencing: accept, recompute steps, result handoff
    cst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // calendar registers, carry chain, count arithmetic, result word
    cst_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .sts      (sts),
        .m_tdata  (m_tdata)
    );

endmodule
